FILE: src/ir_wall_follow_pid_controller_assert.svh
// Assertion macros for the IR wall-follow PID controller.
`ifndef IR_WALL_FOLLOW_PID_CONTROLLER_ASSERT_SVH
`define IR_WALL_FOLLOW_PID_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define IRWF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define IRWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IRWF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define IRWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: src/irwf_pkg.sv
// Package: types, constants and codes of the IR wall-follow PID controller.
package irwf_pkg;

    // Sensor sampling and distance conversion
    localparam int SAMPLE_COUNT = 5;
    localparam int DEN_SUM_MUL  = 500;
    localparam int DEN_OFFSET   = 10230 * SAMPLE_COUNT;
    localparam int DEN_LOW      = 5115 * SAMPLE_COUNT;
    localparam int DEN_HIGH     = 317130 * SAMPLE_COUNT;
    localparam int DIST_NUM2    = 2 * 234 * 1023 * SAMPLE_COUNT * 256;

    localparam int SUM_W   = 13;
    localparam int SCALE_W = 22;
    localparam int DEN_W   = 21;
    localparam int REM_W   = DEN_W + 1;
    localparam int NUM_W   = 30;
    localparam int QUOT_W  = 16;
    localparam int DIST_W  = 12;

    localparam int DIST_MIN = 512;
    localparam int DIST_MAX = 3840;

    // PID
    localparam int ERR_W          = 13;
    localparam int INTEG_W        = 16;
    localparam int DERIV_W        = 14;
    localparam int GAIN_W         = 16;
    localparam int OPND_W         = 16;
    localparam int PROD_W         = GAIN_W + 1 + OPND_W;
    localparam int ACC_W          = PROD_W + 1;
    localparam int GAIN_SHIFT     = 20;
    localparam int INTEGRAL_LIMIT = 12800;
    localparam int DUTY_W         = 8;
    localparam int TURN_DUTY      = 150;
    localparam int DUTY_MAX       = 255;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TARGET   = 3'd0,
        CFG_GAIN_P   = 3'd1,
        CFG_GAIN_I   = 3'd2,
        CFG_GAIN_D   = 3'd3,
        CFG_CRUISE   = 3'd4,
        CFG_OBSTACLE = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_CLAMP,
        ST_DECIDE,
        ST_MUL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [SUM_W-1:0] front_adc_sum;
        logic [SUM_W-1:0] side_adc_sum;
    } t_in;

    typedef struct packed {
        logic              obstacle_turn;
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic [DIST_W-1:0] front_distance;
        logic [DIST_W-1:0] side_distance;
    } t_out;

endpackage

FILE: src/ir_wall_follow_pid_controller.sv
// IR wall-follow PID controller: iterative divider and shared multiplier under a sequencer.
// Each sensor distance goes through setup, 16 restoring-divide steps and a clamp.
// The PID shares one multiplier across its P, I and D products, used in turn.
// Input is accepted only in idle; a finished result waits in the output register.
// Synchronous active-low reset restores register defaults and clears PID state.
`include "ir_wall_follow_pid_controller_assert.svh"

module ir_wall_follow_pid_controller
    import irwf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data
);

    // Configuration registers
    logic [DIST_W-1:0] r_target;
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;
    logic [DUTY_W-1:0] r_cruise;
    logic [DIST_W-1:0] r_obstacle;

    // Sequencer and datapath
    t_state r_state, n_state;
    logic [SUM_W-1:0]  r_front_sum, r_side_sum;
    logic              r_sel;
    logic [DEN_W-1:0]  r_den;
    logic [REM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_num;
    logic [3:0]        r_cnt;
    logic [DIST_W-1:0] r_front, r_side;
    logic              r_turn;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_prev;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DERIV_W-1:0] r_deriv;
    logic [1:0]                r_step;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    t_out                      r_out;

    // Control strobes
    logic w_accept;
    logic w_load_out;
    logic w_out_free;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= DIST_W'(2048);
            r_gain_p   <= GAIN_W'(10240);
            r_gain_i   <= GAIN_W'(41);
            r_gain_d   <= GAIN_W'(4915);
            r_cruise   <= DUTY_W'(120);
            r_obstacle <= DIST_W'(2048);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TARGET:   r_target   <= i_cfg_wdata[DIST_W-1:0];
                CFG_GAIN_P:   r_gain_p   <= i_cfg_wdata;
                CFG_GAIN_I:   r_gain_i   <= i_cfg_wdata;
                CFG_GAIN_D:   r_gain_d   <= i_cfg_wdata;
                CFG_CRUISE:   r_cruise   <= i_cfg_wdata[DUTY_W-1:0];
                CFG_OBSTACLE: r_obstacle <= i_cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Denominator: 500*sum - offset, clamped to the voltage window
    logic [SUM_W-1:0]          w_sum;
    logic [SCALE_W-1:0]        w_scaled;
    logic signed [SCALE_W:0]   w_diff;
    logic [DEN_W-1:0]          w_den;
    logic [NUM_W-1:0]          w_numer;

    always_comb begin
        w_sum    = r_sel ? r_side_sum : r_front_sum;
        w_scaled = SCALE_W'(w_sum) * SCALE_W'(DEN_SUM_MUL);
        w_diff   = $signed({1'b0, w_scaled}) - $signed((SCALE_W+1)'(DEN_OFFSET));
        priority if (w_diff < $signed((SCALE_W+1)'(DEN_LOW))) begin
            w_den = DEN_W'(DEN_LOW);
        end else if (w_diff > $signed((SCALE_W+1)'(DEN_HIGH))) begin
            w_den = DEN_W'(DEN_HIGH);
        end else begin
            w_den = w_diff[DEN_W-1:0];
        end
        w_numer = NUM_W'(DIST_NUM2) + NUM_W'(w_den);
    end

    // One restoring divide step: quotient bits shift into r_num
    logic [REM_W:0]   w_trial;
    logic [REM_W-1:0] w_div2;
    logic             w_ge;

    always_comb begin
        w_div2  = {r_den, 1'b0};
        w_trial = {r_rem, r_num[QUOT_W-1]};
        w_ge    = (w_trial >= {1'b0, w_div2});
    end

    // Quotient clamp to the 2..15 cm range
    logic [DIST_W-1:0] w_dist;

    always_comb begin
        priority if (r_num < QUOT_W'(DIST_MIN)) begin
            w_dist = DIST_W'(DIST_MIN);
        end else if (r_num > QUOT_W'(DIST_MAX)) begin
            w_dist = DIST_W'(DIST_MAX);
        end else begin
            w_dist = r_num[DIST_W-1:0];
        end
    end

    // Error, clamped integral and derivative
    logic signed [ERR_W-1:0]   w_err;
    logic signed [INTEG_W:0]   w_isum;
    logic signed [INTEG_W-1:0] w_integ;
    logic signed [DERIV_W-1:0] w_deriv;
    logic                      w_turn;

    always_comb begin
        w_turn = (r_front < r_obstacle);
        w_err  = $signed({1'b0, r_target}) - $signed({1'b0, r_side});
        w_isum = INTEG_W'(0) + (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(w_err);
        priority if (w_isum < $signed((INTEG_W+1)'(-INTEGRAL_LIMIT))) begin
            w_integ = INTEG_W'(-INTEGRAL_LIMIT);
        end else if (w_isum > $signed((INTEG_W+1)'(INTEGRAL_LIMIT))) begin
            w_integ = INTEG_W'(INTEGRAL_LIMIT);
        end else begin
            w_integ = w_isum[INTEG_W-1:0];
        end
        w_deriv = DERIV_W'(w_err) - DERIV_W'(r_prev);
    end

    // Shared multiplier: gain times signed operand
    logic [GAIN_W-1:0]        w_gain;
    logic signed [OPND_W-1:0] w_opnd;
    logic signed [PROD_W-1:0] w_prod;

    always_comb begin
        unique case (r_step)
            2'd0: begin
                w_gain = r_gain_p;
                w_opnd = OPND_W'(r_err);
            end
            2'd1: begin
                w_gain = r_gain_i;
                w_opnd = OPND_W'(r_integ);
            end
            2'd2: begin
                w_gain = r_gain_d;
                w_opnd = OPND_W'(r_deriv);
            end
            default: begin
                w_gain = '0;
                w_opnd = '0;
            end
        endcase
        w_prod = $signed({1'b0, w_gain}) * w_opnd;
    end

    // Truncate toward zero, then steer around the cruise duty
    logic [ACC_W-1:0]          w_mag;
    logic [ACC_W-GAIN_SHIFT-1:0] w_u_mag;
    logic signed [ACC_W-GAIN_SHIFT+1:0] w_u;
    logic signed [ACC_W-GAIN_SHIFT+1:0] w_left, w_right;
    logic [DUTY_W-1:0]         w_left_duty, w_right_duty;

    always_comb begin
        w_mag   = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        w_u_mag = w_mag[ACC_W-1:GAIN_SHIFT];
        w_u     = r_acc[ACC_W-1] ? -$signed({2'b00, w_u_mag}) : $signed({2'b00, w_u_mag});
        w_left  = $signed({{(ACC_W-GAIN_SHIFT+2-DUTY_W){1'b0}}, r_cruise}) + w_u;
        w_right = $signed({{(ACC_W-GAIN_SHIFT+2-DUTY_W){1'b0}}, r_cruise}) - w_u;
        priority if (w_left < 0) begin
            w_left_duty = '0;
        end else if (w_left > $signed((ACC_W-GAIN_SHIFT+2)'(DUTY_MAX))) begin
            w_left_duty = DUTY_W'(DUTY_MAX);
        end else begin
            w_left_duty = w_left[DUTY_W-1:0];
        end
        priority if (w_right < 0) begin
            w_right_duty = '0;
        end else if (w_right > $signed((ACC_W-GAIN_SHIFT+2)'(DUTY_MAX))) begin
            w_right_duty = DUTY_W'(DUTY_MAX);
        end else begin
            w_right_duty = w_right[DUTY_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_PREP;
            ST_PREP:   n_state = ST_DIV;
            ST_DIV:    if (r_cnt == 4'd15) n_state = ST_CLAMP;
            ST_CLAMP:  n_state = r_sel ? ST_DECIDE : ST_PREP;
            ST_DECIDE: n_state = w_turn ? ST_FINISH : ST_MUL;
            ST_MUL:    if (r_step == 2'd3) n_state = ST_FINISH;
            ST_FINISH: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        w_out_free = !r_out_valid || i_out_ready;
        o_in_ready = (r_state == ST_IDLE);
        w_accept   = o_in_ready && i_in_valid;
        w_load_out = (r_state == ST_FINISH) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_front_sum <= i_in_data.front_adc_sum;
                        r_side_sum  <= i_in_data.side_adc_sum;
                        r_sel       <= 1'b0;
                    end
                end
                ST_PREP: begin
                    r_den <= w_den;
                    r_rem <= REM_W'(w_numer[NUM_W-1:QUOT_W]);
                    r_num <= w_numer[QUOT_W-1:0];
                    r_cnt <= '0;
                end
                ST_DIV: begin
                    r_rem <= w_ge ? REM_W'(w_trial - {1'b0, w_div2}) : w_trial[REM_W-1:0];
                    r_num <= {r_num[QUOT_W-2:0], w_ge};
                    r_cnt <= r_cnt + 4'd1;
                end
                ST_CLAMP: begin
                    if (r_sel) begin
                        r_side <= w_dist;
                    end else begin
                        r_front <= w_dist;
                    end
                    r_sel <= 1'b1;
                end
                ST_DECIDE: begin
                    r_turn <= w_turn;
                    r_step <= '0;
                    r_prod <= '0;
                    r_acc  <= '0;
                    if (w_turn) begin
                        r_integ <= '0;
                        r_prev  <= '0;
                    end else begin
                        r_err   <= w_err;
                        r_deriv <= w_deriv;
                        r_integ <= w_integ;
                        r_prev  <= w_err;
                    end
                end
                ST_MUL: begin
                    r_prod <= w_prod;
                    r_acc  <= r_acc + ACC_W'(r_prod);
                    r_step <= r_step + 2'd1;
                end
                ST_FINISH: ;
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.obstacle_turn  <= r_turn;
            r_out.left_duty      <= r_turn ? DUTY_W'(TURN_DUTY) : w_left_duty;
            r_out.right_duty     <= r_turn ? DUTY_W'(TURN_DUTY) : w_right_duty;
            r_out.front_distance <= r_front;
            r_out.side_distance  <= r_side;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Assertions
    `IRWF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == ST_PREP,
                      "accept did not start conversion")
    `IRWF_ASSERT_IMPL(a_div_rem, i_clk, i_rst_n, r_state == ST_DIV, r_rem < w_div2,
                      "divider remainder out of range")
    `IRWF_ASSERT_IMPL(a_integ_bound, i_clk, i_rst_n, 1'b1,
                      (r_integ <= $signed(INTEG_W'(INTEGRAL_LIMIT))) &&
                      (r_integ >= $signed(INTEG_W'(-INTEGRAL_LIMIT))),
                      "integral out of bounds")
    `IRWF_ASSERT_IMPL(a_turn_duty, i_clk, i_rst_n,
                      o_out_valid && o_out_data.obstacle_turn,
                      (o_out_data.left_duty == DUTY_W'(TURN_DUTY)) &&
                      (o_out_data.right_duty == DUTY_W'(TURN_DUTY)),
                      "turn duty mismatch")

endmodule
